// ===== hw/rtl/vna_pkg.sv =====
`timescale 1ns / 1ps
// vna_pkg: shared types and constants of the vertex normal accumulator
// no dependencies; imported by the top level, the root/divide unit and the checker

package vna_pkg;

  // field widths
  localparam int IDX_W = 10;
  localparam int POS_W = 16;
  localparam int NRM_W = 24;

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_TRI    = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // iteration counts of the shared compare-subtract unit
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 15;

  // control from the sequencer to the root/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } vna_unit_ctl_t;

endpackage

// ===== hw/rtl/vna_root_div.sv =====
`timescale 1ns / 1ps
// vna_root_div: shared bit-serial unit for integer square root and division
// depends on vna_pkg (unit control struct, step counts)

module vna_root_div import vna_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  vna_unit_ctl_t ctl,
  input  logic [61:0]   operand,
  input  logic [30:0]   divisor,
  output logic          done,
  output logic [30:0]   result
);

  logic        busy;
  logic        is_div;
  logic [33:0] rem;
  logic [61:0] bits;
  logic [30:0] root;
  logic [4:0]  steps;
  logic [33:0] cand;
  logic [33:0] trial;
  logic        ge;

  // one compare-subtract step, shared by both modes
  always_comb begin
    if (is_div) begin
      cand  = {rem[32:0], bits[61]};
      trial = {3'b000, divisor};
    end else begin
      cand  = {rem[31:0], bits[61:60]};
      trial = {1'b0, root, 2'b01};
    end
    ge = (cand >= trial);
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy   <= 1'b1;
        is_div <= ctl.is_div;
        root   <= '0;
        if (ctl.is_div) begin
          rem   <= {4'b0000, operand[44:15]};
          bits  <= {operand[14:0], 47'b0};
          steps <= 5'(DIV_STEPS - 1);
        end else begin
          rem   <= '0;
          bits  <= operand;
          steps <= 5'(SQRT_STEPS - 1);
        end
      end else if (busy) begin
        bits <= is_div ? {bits[60:0], 1'b0} : {bits[59:0], 2'b00};
        rem  <= ge ? (cand - trial) : cand;
        root <= {root[29:0], ge};
        if (steps == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          steps <= steps - 5'd1;
        end
      end
    end
  end

  assign result = root;

endmodule

// ===== hw/rtl/vertex_normal_accumulator.sv =====
`timescale 1ns / 1ps
// vertex normal accumulator: load does not stall input; read latches the normal memory output and
// then the result in S_RDN (zeros, in the next cycle, for an index out of table) and holds it until
// taken, input stalled meanwhile. triangle stalls input until it ends: 3 position reads, 6 cross
// products and 3 squares on one multiplier, a 31-step square root and three 15-step divides
// in the shared unit, three read-modify-writes of the normal memory; degenerate ends after the squares.
// synchronous reset clears the sequencer and output valid; memories are not cleared.

module vertex_normal_accumulator import vna_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              req_type,
  input  logic [IDX_W-1:0]        vertex_index,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [IDX_W-1:0]        corner_a,
  input  logic [IDX_W-1:0]        corner_b,
  input  logic [IDX_W-1:0]        corner_c,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z
);

  localparam int DEPTH = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam int AW = $clog2(DEPTH);
  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

  typedef enum logic [3:0] {
    S_IDLE, S_RDB, S_RDC, S_EDGE, S_CROSS, S_MAG, S_SCALE, S_SQ,
    S_SQRT_GO, S_SQRT_WAIT, S_DIV_GO, S_DIV_WAIT, S_NRD, S_NWR, S_RDN, S_OUT
  } state_t;

  state_t state;
  logic [2:0] cnt;
  logic [1:0] k;

  logic accept;
  logic vi_ok;
  logic tri_ok;

  logic [AW-1:0] ca, cb, cc, corner_sel;
  logic [47:0] pa;
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [33:0] cr [3];
  logic [32:0] mag [3];
  logic        sgn [3];
  logic [29:0] mg [3];
  logic [61:0] sum;
  logic [30:0] norm;
  logic signed [15:0] un [3];

  logic [32:0] mx;
  logic [1:0]  shamt;
  logic [44:0] div_num;

  // multiplier
  logic signed [30:0] mul_a, mul_b;
  logic signed [61:0] prod;

  // memories
  logic [47:0]   pos_mem [DEPTH];
  logic [47:0]   pos_rd;
  logic [AW-1:0] pos_raddr;
  logic          pos_we;
  logic [71:0]   nrm_mem [DEPTH];
  logic [71:0]   nrm_rd;
  logic [AW-1:0] nrm_raddr;
  logic [AW-1:0] nrm_waddr;
  logic [71:0]   nrm_wdata;
  logic          nrm_we;

  // shared unit
  vna_unit_ctl_t unit_ctl;
  logic          unit_done;
  logic [30:0]   unit_res;

  function automatic logic signed [NRM_W-1:0] sat_add(
    input logic signed [NRM_W-1:0] a,
    input logic signed [15:0] b
  );
    logic signed [NRM_W:0] s;
    s = {a[NRM_W-1], a} + {{(NRM_W-15){b[15]}}, b};
    if (s[NRM_W] != s[NRM_W-1]) begin
      sat_add = s[NRM_W] ? {1'b1, {(NRM_W-1){1'b0}}} : {1'b0, {(NRM_W-1){1'b1}}};
    end else begin
      sat_add = s[NRM_W-1:0];
    end
  endfunction

  // handshake and range checks
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign vi_ok    = ({7'b0, vertex_index} < MAXV);
  assign tri_ok   = ({7'b0, corner_a} < MAXV) && ({7'b0, corner_b} < MAXV) &&
                    ({7'b0, corner_c} < MAXV);
  assign k        = (cnt[1:0] == 2'd3) ? 2'd2 : cnt[1:0];

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    corner_sel = ca;
      2'd1:    corner_sel = cb;
      default: corner_sel = cc;
    endcase
  end

  // memory addressing
  always_comb begin
    unique case (state)
      S_IDLE:  pos_raddr = corner_a[AW-1:0];
      S_RDB:   pos_raddr = cb;
      default: pos_raddr = cc;
    endcase
    nrm_raddr = (state == S_IDLE) ? vertex_index[AW-1:0] : corner_sel;
    pos_we    = accept && (req_type == REQ_LOAD) && vi_ok;
    nrm_we    = pos_we || (state == S_NWR);
    nrm_waddr = (state == S_NWR) ? corner_sel : vertex_index[AW-1:0];
    if (state == S_NWR) begin
      nrm_wdata = {sat_add(nrm_rd[71:48], un[2]), sat_add(nrm_rd[47:24], un[1]),
                   sat_add(nrm_rd[23:0], un[0])};
    end else begin
      nrm_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[vertex_index[AW-1:0]] <= {pos_z, pos_y, pos_x};
    end
    pos_rd <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (nrm_we) begin
      nrm_mem[nrm_waddr] <= nrm_wdata;
    end
    nrm_rd <= nrm_mem[nrm_raddr];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_CROSS) begin
      unique case (cnt)
        3'd0: begin mul_a = 31'(e1[1]); mul_b = 31'(e2[2]); end
        3'd1: begin mul_a = 31'(e1[2]); mul_b = 31'(e2[1]); end
        3'd2: begin mul_a = 31'(e1[2]); mul_b = 31'(e2[0]); end
        3'd3: begin mul_a = 31'(e1[0]); mul_b = 31'(e2[2]); end
        3'd4: begin mul_a = 31'(e1[0]); mul_b = 31'(e2[1]); end
        3'd5: begin mul_a = 31'(e1[1]); mul_b = 31'(e2[0]); end
        default: ;
      endcase
    end else if (state == S_SQ && cnt != 3'd3) begin
      mul_a = {1'b0, mg[k]};
      mul_b = {1'b0, mg[k]};
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // scale search and divide numerator
  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    priority if (mx[32]) shamt = 2'd3;
    else if (mx[31])     shamt = 2'd2;
    else if (mx[30])     shamt = 2'd1;
    else                 shamt = 2'd0;
    div_num = {1'b0, mg[k], 14'b0} + {15'b0, norm[30:1]};
  end

  assign unit_ctl.start  = ((state == S_SQRT_GO) && (sum != '0)) || (state == S_DIV_GO);
  assign unit_ctl.is_div = (state == S_DIV_GO);

  vna_root_div u_root_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     (unit_ctl),
    .operand ((state == S_DIV_GO) ? {17'b0, div_num} : sum),
    .divisor (norm),
    .done    (unit_done),
    .result  (unit_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            unique case (req_type)
              REQ_TRI: begin
                if (tri_ok) begin
                  ca    <= corner_a[AW-1:0];
                  cb    <= corner_b[AW-1:0];
                  cc    <= corner_c[AW-1:0];
                  state <= S_RDB;
                end
              end
              REQ_READ: begin
                out_index <= vertex_index;
                if (vi_ok) begin
                  state <= S_RDN;
                end else begin
                  normal_x  <= '0;
                  normal_y  <= '0;
                  normal_z  <= '0;
                  out_valid <= 1'b1;
                  state     <= S_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_RDB: begin
          pa    <= pos_rd;
          state <= S_RDC;
        end
        S_RDC: begin
          e1[0] <= {pa[15], pa[15:0]} - {pos_rd[15], pos_rd[15:0]};
          e1[1] <= {pa[31], pa[31:16]} - {pos_rd[31], pos_rd[31:16]};
          e1[2] <= {pa[47], pa[47:32]} - {pos_rd[47], pos_rd[47:32]};
          state <= S_EDGE;
        end
        S_EDGE: begin
          e2[0] <= {pa[15], pa[15:0]} - {pos_rd[15], pos_rd[15:0]};
          e2[1] <= {pa[31], pa[31:16]} - {pos_rd[31], pos_rd[31:16]};
          e2[2] <= {pa[47], pa[47:32]} - {pos_rd[47], pos_rd[47:32]};
          cnt   <= '0;
          state <= S_CROSS;
        end
        // product of step n is registered and used at step n+1
        S_CROSS: begin
          cnt <= cnt + 3'd1;
          unique case (cnt)
            3'd1: cr[0] <= prod[33:0];
            3'd2: cr[0] <= cr[0] - prod[33:0];
            3'd3: cr[1] <= prod[33:0];
            3'd4: cr[1] <= cr[1] - prod[33:0];
            3'd5: cr[2] <= prod[33:0];
            3'd6: begin
              cr[2] <= cr[2] - prod[33:0];
              state <= S_MAG;
            end
            default: ;
          endcase
        end
        S_MAG: begin
          for (int j = 0; j < 3; j++) begin
            sgn[j] <= cr[j][33];
            mag[j] <= cr[j][33] ? 33'(-cr[j]) : cr[j][32:0];
          end
          state <= S_SCALE;
        end
        S_SCALE: begin
          for (int j = 0; j < 3; j++) begin
            mg[j] <= 30'(mag[j] >> shamt);
          end
          sum   <= '0;
          cnt   <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) begin
            sum <= sum + $unsigned(prod);
          end
          if (cnt == 3'd3) begin
            state <= S_SQRT_GO;
          end
        end
        // degenerate triangle adds nothing
        S_SQRT_GO: begin
          state <= (sum == '0) ? S_IDLE : S_SQRT_WAIT;
        end
        S_SQRT_WAIT: begin
          if (unit_done) begin
            norm  <= unit_res;
            cnt   <= '0;
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (unit_done) begin
            un[k] <= sgn[k] ? -{1'b0, unit_res[14:0]} : {1'b0, unit_res[14:0]};
            if (cnt == 3'd2) begin
              cnt   <= '0;
              state <= S_NRD;
            end else begin
              cnt   <= cnt + 3'd1;
              state <= S_DIV_GO;
            end
          end
        end
        S_NRD: begin
          state <= S_NWR;
        end
        S_NWR: begin
          if (cnt == 3'd2) begin
            state <= S_IDLE;
          end else begin
            cnt   <= cnt + 3'd1;
            state <= S_NRD;
          end
        end
        S_RDN: begin
          normal_x  <= nrm_rd[23:0];
          normal_y  <= nrm_rd[47:24];
          normal_z  <= nrm_rd[71:48];
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/vna_checker.sv =====
`timescale 1ns / 1ps
// vna_props: port-level assertions for the vertex normal accumulator, with its bind
// depends on vna_pkg (request codes, field widths)

module vna_props import vna_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              req_type,
  input logic [IDX_W-1:0]        vertex_index,
  input logic signed [POS_W-1:0] pos_x,
  input logic signed [POS_W-1:0] pos_y,
  input logic signed [POS_W-1:0] pos_z,
  input logic [IDX_W-1:0]        corner_a,
  input logic [IDX_W-1:0]        corner_b,
  input logic [IDX_W-1:0]        corner_c,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [IDX_W-1:0]        out_index,
  input logic signed [NRM_W-1:0] normal_x,
  input logic signed [NRM_W-1:0] normal_y,
  input logic signed [NRM_W-1:0] normal_z
);

  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // no new transfer while a result waits
  a_busy_when_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // read of an index out of table answers next cycle with zero normal
  a_read_oor: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (req_type == REQ_READ) && ({7'b0, vertex_index} >= MAXV) |=>
      out_valid && (out_index == $past(vertex_index)) && (normal_x == '0) &&
      (normal_y == '0) && (normal_z == '0))
    else $error("bad answer to out of table read");

  // a valid triangle keeps the block busy
  a_tri_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (req_type == REQ_TRI) && ({7'b0, corner_a} < MAXV) &&
      ({7'b0, corner_b} < MAXV) && ({7'b0, corner_c} < MAXV) |=> in_stall && !out_valid)
    else $error("triangle did not occupy the block");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_index) && $stable(normal_x) &&
      $stable(normal_y) && $stable(normal_z))
    else $error("stalled result changed");

endmodule

bind vertex_normal_accumulator vna_props #(.MAX_VERTICES(MAX_VERTICES)) u_vna_props (.*);
